@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL that checks itself.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define CHK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The antecedent at one edge implies the consequent at the next edge.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/csjh_pkg.sv @@
// Shared types, constants and the CRC-32C nibble step for the jump hash block.
// No dependencies.
package csjh_pkg;

	localparam int BUCKET_BITS_DEF = 16;
	localparam logic [63:0] LCG_MULT = 64'd2862933555777941757;
	localparam logic [31:0] CRC_POLY = 32'h82F63B78;
	localparam int CRC_BITS_PER_STEP = 4;
	localparam int CRC_STEPS = 32 / CRC_BITS_PER_STEP;

	localparam logic [1:0] MUL_LL = 2'd0;
	localparam logic [1:0] MUL_LH = 2'd1;
	localparam logic [1:0] MUL_HL = 2'd2;

	typedef struct packed {
		logic       load;
		logic       crc_step;
		logic       k_init;
		logic       mul_en;
		logic [1:0] mul_op;
		logic       div_init;
		logic       div_step;
		logic       next_b;
	} cmd_t;

	typedef struct packed {
		logic cnt_ok;
		logic j_lt_n;
	} sts_t;

	// Four bit steps of the reflected CRC-32C shift register.
	function automatic logic [31:0] crc_nib(input logic [31:0] c);
		logic [31:0] r;
		r = c;
		for (int i = 0; i < CRC_BITS_PER_STEP; i++) begin
			r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
		end
		return r;
	endfunction

endpackage

@@ rtl/core/csjh_datapath.sv @@
// Datapath of the jump hash: CRC registers, LCG multiplier and restoring divider.
// Depends on csjh_pkg.
module csjh_datapath #(
	parameter int BUCKET_BITS = csjh_pkg::BUCKET_BITS_DEF
) (
	input  logic                   clk,
	input  logic [63:0]            key,
	input  logic [31:0]            seed,
	input  logic [BUCKET_BITS:0]   bucket_count,
	input  logic                   scramble_first,
	input  csjh_pkg::cmd_t         cmd,
	output csjh_pkg::sts_t         sts,
	output logic [BUCKET_BITS-1:0] bucket,
	output logic [63:0]            scrambled_key,
	output logic                   count_invalid
);
	import csjh_pkg::*;

	localparam int NUM_W = BUCKET_BITS + 32;

	logic [63:0]            key_q;
	logic [BUCKET_BITS:0]   n_q;
	logic                   sel_q;
	logic [31:0]            crc_lo_q;
	logic [31:0]            crc_hi_q;
	logic [63:0]            k_q;
	logic [63:0]            acc_q;
	logic [BUCKET_BITS-1:0] b_q;
	logic [NUM_W-1:0]       num_q;
	logic [31:0]            rem_q;
	logic [31:0]            d_q;

	logic [31:0]            mul_a;
	logic [31:0]            mul_b;
	logic [63:0]            prod;
	logic [32:0]            rem_sh;
	logic                   fits;
	logic [BUCKET_BITS:0]   b_inc;

	always_comb begin
		unique case (cmd.mul_op)
			MUL_LL: begin
				mul_a = k_q[31:0];
				mul_b = LCG_MULT[31:0];
			end
			MUL_LH: begin
				mul_a = k_q[31:0];
				mul_b = LCG_MULT[63:32];
			end
			MUL_HL: begin
				mul_a = k_q[63:32];
				mul_b = LCG_MULT[31:0];
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	assign prod   = {32'd0, mul_a} * {32'd0, mul_b};
	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, d_q};
	assign b_inc  = {1'b0, b_q} + {{BUCKET_BITS{1'b0}}, 1'b1};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q    <= key;
			n_q      <= bucket_count;
			sel_q    <= scramble_first;
			crc_lo_q <= seed ^ key[31:0];
			crc_hi_q <= seed ^ key[63:32];
			b_q      <= '0;
		end
		if (cmd.crc_step) begin
			crc_lo_q <= crc_nib(crc_lo_q);
			crc_hi_q <= crc_nib(crc_hi_q);
		end
		if (cmd.k_init) begin
			k_q <= sel_q ? {crc_hi_q, crc_lo_q} : key_q;
		end
		if (cmd.mul_en) begin
			unique case (cmd.mul_op)
				MUL_LL: acc_q <= prod;
				MUL_LH: acc_q[63:32] <= acc_q[63:32] + prod[31:0];
				MUL_HL: k_q <= {acc_q[63:32] + prod[31:0], acc_q[31:0]} + 64'd1;
				default: acc_q <= acc_q;
			endcase
		end
		if (cmd.div_init) begin
			num_q <= {b_inc, 31'd0};
			rem_q <= '0;
			d_q   <= {1'b0, k_q[63:33]} + 32'd1;
		end
		if (cmd.div_step) begin
			if (fits) begin
				rem_q <= 32'(rem_sh - {1'b0, d_q});
				num_q <= {num_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				num_q <= {num_q[NUM_W-2:0], 1'b0};
			end
		end
		if (cmd.next_b) begin
			b_q <= num_q[BUCKET_BITS-1:0];
		end
	end

	assign sts.cnt_ok = (n_q != '0) && (n_q <= {1'b1, {BUCKET_BITS{1'b0}}});
	assign sts.j_lt_n = num_q < NUM_W'(n_q);

	assign count_invalid = !sts.cnt_ok;
	assign bucket        = sts.cnt_ok ? b_q : '0;
	assign scrambled_key = {crc_hi_q, crc_lo_q};

endmodule

@@ rtl/core/csjh_ctrl.sv @@
// Controller state machine sequencing CRC, LCG steps and division of the jump hash.
// Depends on csjh_pkg.
module csjh_ctrl #(
	parameter int BUCKET_BITS = csjh_pkg::BUCKET_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           out_free,
	output logic           out_load,
	input  csjh_pkg::sts_t sts,
	output csjh_pkg::cmd_t cmd
);
	import csjh_pkg::*;

	localparam int NUM_W = BUCKET_BITS + 32;
	localparam int CNT_W = $clog2(NUM_W);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CRC   = 4'd1;
	localparam logic [3:0] S_KINIT = 4'd2;
	localparam logic [3:0] S_MLL   = 4'd3;
	localparam logic [3:0] S_MLH   = 4'd4;
	localparam logic [3:0] S_MHL   = 4'd5;
	localparam logic [3:0] S_DINIT = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_CHK   = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0]       state_q;
	logic [3:0]       state_nx;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_nx;

	always_comb begin
		state_nx = state_q;
		cnt_nx   = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_nx   = '0;
					state_nx = S_CRC;
				end
			end
			S_CRC: begin
				cmd.crc_step = 1'b1;
				cnt_nx       = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(CRC_STEPS - 1)) begin
					state_nx = sts.cnt_ok ? S_KINIT : S_DONE;
				end
			end
			S_KINIT: begin
				cmd.k_init = 1'b1;
				state_nx   = S_MLL;
			end
			S_MLL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_LL;
				state_nx   = S_MLH;
			end
			S_MLH: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_LH;
				state_nx   = S_MHL;
			end
			S_MHL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_HL;
				state_nx   = S_DINIT;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				cnt_nx       = '0;
				state_nx     = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_nx       = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					state_nx = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.j_lt_n) begin
					cmd.next_b = 1'b1;
					state_nx   = S_MLL;
				end else begin
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			cnt_q   <= cnt_nx;
		end
	end

endmodule

@@ rtl/core/crc_scrambled_jump_hash.sv @@
// An invalid count runs eight CRC nibble steps, then the done state. A valid count runs the eight
// CRC nibble steps, a key setup, I jump iterations (about ln(bucket_count) + 1) and the done
// state. Each iteration is three 32x32 multiply steps, one division setup, BUCKET_BITS + 32
// restoring divide steps and one compare. The done state waits until the output slot is free.
// Items are handled one at a time, the next taken at the earliest in the cycle after the result
// is loaded. Reset (arst_n, asynchronous, active low) clears the controller and the output valid.
`include "assert_macros.svh"

module crc_scrambled_jump_hash #(
	parameter int BUCKET_BITS = csjh_pkg::BUCKET_BITS_DEF,
	localparam int S_DW = ((96 + BUCKET_BITS + 1 + 7) / 8) * 8,
	localparam int M_DW = ((BUCKET_BITS + 64 + 7) / 8) * 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	// key [63:0], seed [95:64], bucket_count [96 +: BUCKET_BITS+1], zero fill above
	input  logic [S_DW-1:0] s_tdata,
	// scramble_first
	input  logic            s_tuser,
	output logic            m_tvalid,
	input  logic            m_tready,
	// bucket [BUCKET_BITS-1:0], scrambled_key above it, zero fill above
	output logic [M_DW-1:0] m_tdata,
	// count_invalid
	output logic            m_tuser
);
	import csjh_pkg::*;

	cmd_t cmd;
	sts_t sts;

	logic                   out_free;
	logic                   out_load;
	logic [BUCKET_BITS-1:0] dp_bucket;
	logic [63:0]            dp_scr;
	logic                   dp_inv;

	logic                   m_tvalid_q;
	logic [BUCKET_BITS-1:0] bucket_q;
	logic [63:0]            scr_q;
	logic                   inv_q;

	// The output slot is free when empty or when its transfer completes this cycle.
	assign out_free = !m_tvalid_q || m_tready;

	csjh_ctrl #(.BUCKET_BITS(BUCKET_BITS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_free (out_free),
		.out_load (out_load),
		.sts      (sts),
		.cmd      (cmd)
	);

	csjh_datapath #(.BUCKET_BITS(BUCKET_BITS)) u_dp (
		.clk            (clk),
		.key            (s_tdata[63:0]),
		.seed           (s_tdata[95:64]),
		.bucket_count   (s_tdata[96 +: BUCKET_BITS + 1]),
		.scramble_first (s_tuser),
		.cmd            (cmd),
		.sts            (sts),
		.bucket         (dp_bucket),
		.scrambled_key  (dp_scr),
		.count_invalid  (dp_inv)
	);

	// Output register: holds one finished result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			bucket_q <= dp_bucket;
			scr_q    <= dp_scr;
			inv_q    <= dp_inv;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DW'({scr_q, bucket_q});
	assign m_tuser  = inv_q;

	// An invalid count always reports bucket zero.
	`CHK_ALWAYS(a_inv_zero, !(m_tvalid && m_tuser) || (m_tdata[BUCKET_BITS-1:0] == '0), "invalid count with nonzero bucket")
	// Once an item is taken the block stops taking input until it finishes.
	`CHK_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "input taken while busy")
	// A new result never overwrites one still waiting for its transfer.
	`CHK_ALWAYS(a_no_overwrite, !out_load || out_free, "result overwritten")

endmodule

@@ test/crc_scrambled_jump_hash_tb.sv @@
// Testbench for crc_scrambled_jump_hash: CRC-32C key scrambling and jump consistent hash.
// It drives keys over the input stream and checks every bucket against a local predictor.
// Depends on csjh_pkg and the crc_scrambled_jump_hash RTL.
module crc_scrambled_jump_hash_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import csjh_pkg::*;

	localparam int BB = BUCKET_BITS_DEF;
	localparam int S_DW = ((96 + BB + 1 + 7) / 8) * 8;
	localparam int M_DW = ((BB + 64 + 7) / 8) * 8;
	localparam logic [31:0] POLY = 32'h82F63B78;
	localparam logic [63:0] STEP_MULT = 64'd2862933555777941757;

	// One predicted result: the chosen bucket, the scrambled key and the invalid flag.
	typedef struct {
		logic [BB-1:0] bucket;
		logic [63:0]   scrambled;
		logic          invalid;
	} bucket_pick_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [S_DW-1:0] s_tdata = '0;
	logic            s_tuser = 1'b0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [M_DW-1:0] m_tdata;
	logic            m_tuser;

	bucket_pick_t pending_picks[$];
	int           mismatch_count = 0;
	// Idling controls: percentage of idle cycles on each side, plus a forced receiver hold.
	int           send_idle_pct = 26;
	int           recv_idle_pct = 26;
	int           recv_hold_cycles = 0;

	crc_scrambled_jump_hash dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #10 clk = ~clk;

	// Reflected CRC-32C of one 32-bit word, no final inversion.
	function automatic logic [31:0] crc32c_of_word(logic [31:0] word, logic [31:0] start);
		logic [31:0] c;
		c = start ^ word;
		for (int i = 0; i < 32; i++)
			c = (c >> 1) ^ (POLY & {32{c[0]}});
		return c;
	endfunction

	// Jump consistent hash with the exact integer quotient in place of the double division.
	function automatic logic [63:0] jump_to_bucket(logic [63:0] k, logic [63:0] n);
		logic [63:0] b;
		logic [63:0] j;
		b = '0;
		j = '0;
		while (j < n) begin
			b = j;
			k = k * STEP_MULT + 64'd1;
			j = ((b + 64'd1) << 31) / ((k >> 33) + 64'd1);
		end
		return b;
	endfunction

	function automatic bucket_pick_t predict_pick(logic [63:0] key, logic [31:0] seed,
			logic [16:0] count, logic scramble);
		bucket_pick_t p;
		logic [63:0] bkt;
		p.scrambled = {crc32c_of_word(key[63:32], seed), crc32c_of_word(key[31:0], seed)};
		p.invalid = (count == 17'd0) || (count > (17'd1 << BB));
		bkt = '0;
		if (!p.invalid)
			bkt = jump_to_bucket(scramble ? p.scrambled : key, {47'd0, count});
		p.bucket = bkt[BB-1:0];
		return p;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// Sends one item: optional random idle first, then hold valid until the transfer.
	// Valid stays high after the transfer; the next call replaces the item or lowers it, as does wait_drained.
	task automatic send_key(logic [63:0] key, logic [31:0] seed, logic [16:0] count,
			logic scramble);
		logic [S_DW-1:0] word;
		word = '0;
		word[63:0] = key;
		word[95:64] = seed;
		word[96 +: 17] = count;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tuser <= scramble;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_picks.push_back(predict_pick(key, seed, count, scramble));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_picks.size() != 0) @(posedge clk);
	endtask

	// Receiver readiness: random idling, or a long hold while recv_hold_cycles counts down.
	always @(posedge clk) begin
		if (recv_hold_cycles > 0) begin
			recv_hold_cycles <= recv_hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Result checker: every output transfer is compared with the oldest prediction.
	always @(posedge clk) begin
		bucket_pick_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_picks.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[63:0], 64'd0);
			end else begin
				want = pending_picks.pop_front();
				if (m_tdata[BB-1:0] !== want.bucket)
					report_mismatch("bucket", 64'(m_tdata[BB-1:0]), 64'(want.bucket));
				if (m_tdata[BB +: 64] !== want.scrambled)
					report_mismatch("scrambled_key", m_tdata[BB +: 64], want.scrambled);
				if (m_tuser !== want.invalid)
					report_mismatch("count_invalid", 64'(m_tuser), 64'(want.invalid));
			end
		end
	end

	function automatic logic [16:0] random_count();
		int r;
		r = $urandom_range(99);
		// Mostly small counts keep the run short; a few span the whole range.
		if (r < 60) return 17'($urandom_range(1, 64));
		if (r < 85) return 17'($urandom_range(1, 4096));
		if (r < 95) return 17'($urandom_range(1, 65536));
		return $urandom_range(0, 1) ? 17'd0 : 17'($urandom_range(65537, 131071));
	endfunction

	// Extremes of each field, both key sources and both kinds of invalid count.
	task automatic test_directed();
		send_key(64'd0, 32'd0, 17'd1, 1'b0);
		send_key('1, '1, 17'd65536, 1'b1);
		send_key('1, '1, 17'd65536, 1'b0);
		send_key(64'd0, 32'd0, 17'd65536, 1'b1);
		send_key(64'h0123456789ABCDEF, 32'hDEADBEEF, 17'd0, 1'b1);
		send_key(64'h0123456789ABCDEF, 32'hDEADBEEF, 17'd65537, 1'b0);
		send_key('1, '1, 17'h1FFFF, 1'b1);
		send_key(64'h8000000000000000, 32'h80000000, 17'd2, 1'b1);
		send_key(64'h0000000000000001, 32'h00000001, 17'd2, 1'b0);
		send_key(64'hAAAAAAAA55555555, 32'h5A5A5A5A, 17'd1000, 1'b1);
		send_key(64'h55555555AAAAAAAA, 32'hA5A5A5A5, 17'd1000, 1'b0);
		send_key(64'hFFFFFFFF00000000, 32'h0, 17'd7, 1'b1);
		wait_drained();
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++)
			send_key({$urandom, $urandom}, $urandom, random_count(), 1'($urandom_range(1)));
	endtask

	// Stretch without any idling on either side.
	task automatic test_full_rate(int n);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(n);
		wait_drained();
		send_idle_pct = 26;
		recv_idle_pct = 26;
	endtask

	// The receiver holds off while the sender keeps offering, so the block stalls its input.
	task automatic test_back_pressure(int n);
		recv_hold_cycles = 3000;
		test_random(n);
		wait_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_pressure(20);
		test_random(600);
		wait_drained();
		test_full_rate(300);
		test_random(560);
		wait_drained();
		repeat (200) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#200ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/csjh_pkg.sv
rtl/core/csjh_datapath.sv
rtl/core/csjh_ctrl.sv
rtl/core/crc_scrambled_jump_hash.sv
test/crc_scrambled_jump_hash_tb.sv
